FILE: hdl/bom_detect_utf16_to_utf8_transcoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte-order-mark transcoder
// Concurrent check wrappers; defining ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef BOM_DETECT_UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define BOM_DETECT_UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define BDT_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// cons must hold in the same cycle as ante
`define BDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BDT_ASSERT(label, clk, rst, expr, msg)
`define BDT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hdl/bdt_pkg.sv
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and codes for the mark-detecting UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package bdt_pkg;

  // command handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_FEED8  = 2'd1,
    OP_FEED16 = 2'd2
  } op_t;

  localparam logic [1:0] ENC_UTF8     = 2'd0;
  localparam logic [1:0] ENC_UTF8_BOM = 2'd1;
  localparam logic [1:0] ENC_UTF16_LE = 2'd2;
  localparam logic [1:0] ENC_UTF16_BE = 2'd3;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [1:0] enc;   // encoding decided so far
    logic       last;  // last command of the file: back end closes it
  } cmd_t;

endpackage

FILE: hdl/bdt_front.sv
// ----------------------------------------------------------------------------
// bdt_front
// Accepts raw bytes, decides the byte-order mark and turns each item into
// zero to three back-end commands, held in a small shift buffer.
// ----------------------------------------------------------------------------
module bdt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_byte,
  input  logic          final_byte,
  output logic          full,
  output bdt_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_full
);
  import bdt_pkg::*;

  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  typedef enum logic [2:0] {
    M_START, M_HOLD1, M_HOLD2, M_UTF8, M_UTF8_BOM, M_LE, M_BE
  } mode_t;

  mode_t      mode, mode_dec, mode_next;
  logic [7:0] held0, held1;
  logic [7:0] held0_next, held1_next;
  cmd_t       pend [3];
  cmd_t       pend_load [3];
  logic [1:0] pend_cnt;
  logic [1:0] exp_cnt;
  op_t        exp_op;
  logic [7:0] exp_b [3];
  logic [1:0] enc;
  logic       shift, ready, accept;

  always_comb begin
    mode_dec   = mode;
    held0_next = held0;
    held1_next = held1;
    exp_cnt    = 2'd0;
    exp_op     = OP_FEED8;
    exp_b[0]   = in_byte;
    exp_b[1]   = in_byte;
    exp_b[2]   = in_byte;
    unique case (mode)
      M_START: begin
        if (in_byte == BYTE_EF || in_byte == BYTE_FF || in_byte == BYTE_FE) begin
          held0_next = in_byte;
          mode_dec   = M_HOLD1;
          // file ends on a lone candidate byte: flush it
          if (final_byte) begin
            mode_dec = M_UTF8;
            exp_cnt  = 2'd1;
          end
        end else begin
          mode_dec = M_UTF8;
          exp_cnt  = 2'd1;
        end
      end
      M_HOLD1: begin
        if (held0 == BYTE_FF && in_byte == BYTE_FE) begin
          mode_dec = M_LE;
          exp_op   = OP_NOP;
          exp_cnt  = {1'b0, final_byte};
        end else if (held0 == BYTE_FE && in_byte == BYTE_FF) begin
          mode_dec = M_BE;
          exp_op   = OP_NOP;
          exp_cnt  = {1'b0, final_byte};
        end else if (held0 == BYTE_EF && in_byte == BYTE_BB) begin
          held1_next = in_byte;
          mode_dec   = M_HOLD2;
          if (final_byte) begin
            mode_dec = M_UTF8;
            exp_cnt  = 2'd2;
            exp_b[0] = held0;
          end
        end else begin
          mode_dec = M_UTF8;
          exp_cnt  = 2'd2;
          exp_b[0] = held0;
        end
      end
      M_HOLD2: begin
        if (in_byte == BYTE_BF) begin
          mode_dec = M_UTF8_BOM;
          exp_op   = OP_NOP;
          exp_cnt  = {1'b0, final_byte};
        end else begin
          mode_dec = M_UTF8;
          exp_cnt  = 2'd3;
          exp_b[0] = held0;
          exp_b[1] = held1;
        end
      end
      M_LE, M_BE: begin
        exp_op  = OP_FEED16;
        exp_cnt = 2'd1;
      end
      default: begin
        exp_cnt = 2'd1;
      end
    endcase
    mode_next = final_byte ? M_START : mode_dec;
  end

  always_comb begin
    unique case (mode_dec)
      M_UTF8_BOM: enc = ENC_UTF8_BOM;
      M_LE:       enc = ENC_UTF16_LE;
      M_BE:       enc = ENC_UTF16_BE;
      default:    enc = ENC_UTF8;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pend_load[i].op   = exp_op;
      pend_load[i].data = exp_b[i];
      pend_load[i].enc  = enc;
      pend_load[i].last = final_byte && ((2'(i) + 2'd1) == exp_cnt);
    end
  end

  assign cmd_valid = pend_cnt != 2'd0;
  assign cmd       = pend[0];
  assign shift     = cmd_valid && !cmd_full;
  assign ready     = (pend_cnt == 2'd0) || (pend_cnt == 2'd1 && shift);
  assign full      = !ready;
  assign accept    = push && ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_START;
      pend_cnt <= 2'd0;
    end else if (accept) begin
      mode     <= mode_next;
      held0    <= held0_next;
      held1    <= held1_next;
      pend_cnt <= exp_cnt;
      pend     <= pend_load;
    end else if (shift) begin
      pend_cnt <= pend_cnt - 2'd1;
      pend[0]  <= pend[1];
      pend[1]  <= pend[2];
    end
  end

endmodule

FILE: hdl/bdt_fifo.sv
// ----------------------------------------------------------------------------
// bdt_fifo
// Short show-ahead command queue between the front and back ends.
// ----------------------------------------------------------------------------
module bdt_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bdt_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output bdt_pkg::cmd_t rdata,
  output logic          empty
);
  import bdt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slot [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          wr_en, rd_en;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wdata;
    end
  end

endmodule

FILE: hdl/bdt_back.sv
// ----------------------------------------------------------------------------
// bdt_back
// Executes commands: UTF-8 validation and pass-through, UTF-16 decode and
// UTF-8 encode, end-of-file checks. Drains one result per cycle while pop is held.
// ----------------------------------------------------------------------------
module bdt_back (
  input  logic          clk,
  input  logic          rst,
  input  bdt_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    out_byte,
  output logic          has_byte,
  output logic          stream_done,
  output logic [1:0]    detected_encoding,
  output logic          bad_encoding
);
  import bdt_pkg::*;

  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST = 21'h00D800;
  localparam logic [20:0] SURR_LAST  = 21'h00DFFF;
  localparam logic [20:0] MIN_LEN2   = 21'h000080;
  localparam logic [20:0] MIN_LEN3   = 21'h000800;
  localparam logic [20:0] MIN_LEN4   = 21'h010000;
  localparam logic [10:0] PLANE1     = 11'h040;   // 0x10000 >> 10
  localparam logic [5:0]  HI_SURR    = 6'b110110;
  localparam logic [5:0]  LO_SURR    = 6'b110111;

  // decoder state
  logic        error_seen;
  logic [1:0]  utf8_pending, utf8_length;
  logic [20:0] cp_acc;
  logic        half_valid;
  logic [7:0]  half_byte;
  logic        hs_valid;
  logic [9:0]  hs_off;

  logic        err_n;
  logic [1:0]  pend_n, len_n;
  logic [20:0] acc_n;
  logic        hv_n, sv_n;
  logic [7:0]  hb_n;
  logic [9:0]  so_n;
  logic        fin_bad;

  // per-command result buffer
  logic [7:0]  eb_byte [4];
  logic [2:0]  eb_cnt;
  logic        eb_stat, eb_bad;
  logic [1:0]  eb_enc;

  logic [7:0]  x_byte [4];
  logic [2:0]  x_cnt;

  logic [20:0] shifted, lo_bound;
  logic        range_bad;
  logic [15:0] unit;
  logic [20:0] pair_cp, cp_val;
  logic [7:0]  cp_byte [4];
  logic [2:0]  cp_cnt;

  logic        out_valid, out_take, rem_zero, rem_one, move, load_ok, fire;

  assign shifted  = {cp_acc[14:0], cmd.data[5:0]};
  assign lo_bound = (utf8_length == 2'd1) ? MIN_LEN2 :
                    (utf8_length == 2'd2) ? MIN_LEN3 : MIN_LEN4;
  assign range_bad = (shifted < lo_bound) || (shifted > CP_MAX) ||
                     (shifted >= SURR_FIRST && shifted <= SURR_LAST);

  assign unit    = (cmd.enc == ENC_UTF16_LE) ? {cmd.data, half_byte} : {half_byte, cmd.data};
  assign pair_cp = {{1'b0, hs_off} + PLANE1, unit[9:0]};
  assign cp_val  = hs_valid ? pair_cp : {5'd0, unit};

  // UTF-8 encoder for a decoded code point
  always_comb begin
    cp_byte[0] = cp_val[7:0];
    cp_byte[1] = 8'h00;
    cp_byte[2] = 8'h00;
    cp_byte[3] = 8'h00;
    if (cp_val <= 21'h00007F) begin
      cp_cnt = 3'd1;
    end else if (cp_val <= 21'h0007FF) begin
      cp_cnt     = 3'd2;
      cp_byte[0] = {3'b110, cp_val[10:6]};
      cp_byte[1] = {2'b10, cp_val[5:0]};
    end else if (cp_val <= 21'h00FFFF) begin
      cp_cnt     = 3'd3;
      cp_byte[0] = {4'b1110, cp_val[15:12]};
      cp_byte[1] = {2'b10, cp_val[11:6]};
      cp_byte[2] = {2'b10, cp_val[5:0]};
    end else begin
      cp_cnt     = 3'd4;
      cp_byte[0] = {5'b11110, cp_val[20:18]};
      cp_byte[1] = {2'b10, cp_val[17:12]};
      cp_byte[2] = {2'b10, cp_val[11:6]};
      cp_byte[3] = {2'b10, cp_val[5:0]};
    end
  end

  always_comb begin
    err_n     = error_seen;
    pend_n    = utf8_pending;
    len_n     = utf8_length;
    acc_n     = cp_acc;
    hv_n      = half_valid;
    hb_n      = half_byte;
    sv_n      = hs_valid;
    so_n      = hs_off;
    x_cnt     = 3'd0;
    x_byte[0] = cmd.data;
    x_byte[1] = cmd.data;
    x_byte[2] = cmd.data;
    x_byte[3] = cmd.data;
    fin_bad   = 1'b0;
    unique case (cmd.op)
      OP_FEED8: begin
        if (!error_seen) begin
          if (utf8_pending == 2'd0) begin
            priority if (!cmd.data[7]) begin
              x_cnt = 3'd1;
            end else if (cmd.data[7:5] == 3'b110) begin
              acc_n  = {16'd0, cmd.data[4:0]};
              pend_n = 2'd1;
              len_n  = 2'd1;
              x_cnt  = 3'd1;
            end else if (cmd.data[7:4] == 4'b1110) begin
              acc_n  = {17'd0, cmd.data[3:0]};
              pend_n = 2'd2;
              len_n  = 2'd2;
              x_cnt  = 3'd1;
            end else if (cmd.data[7:3] == 5'b11110) begin
              acc_n  = {18'd0, cmd.data[2:0]};
              pend_n = 2'd3;
              len_n  = 2'd3;
              x_cnt  = 3'd1;
            end else begin
              err_n = 1'b1;
            end
          end else if (cmd.data[7:6] != 2'b10) begin
            err_n = 1'b1;
          end else begin
            acc_n  = shifted;
            pend_n = utf8_pending - 2'd1;
            // sequence complete: overlong, range and surrogate checks
            if (utf8_pending == 2'd1 && range_bad) begin
              err_n = 1'b1;
            end else begin
              x_cnt = 3'd1;
            end
          end
        end
      end
      OP_FEED16: begin
        if (!error_seen) begin
          if (!half_valid) begin
            hv_n = 1'b1;
            hb_n = cmd.data;
          end else begin
            hv_n = 1'b0;
            if (hs_valid) begin
              sv_n = 1'b0;
              if (unit[15:10] == LO_SURR) begin
                x_cnt  = cp_cnt;
                x_byte = cp_byte;
              end else begin
                err_n = 1'b1;
              end
            end else if (unit[15:10] == HI_SURR) begin
              sv_n = 1'b1;
              so_n = unit[9:0];
            end else if (unit[15:10] == LO_SURR) begin
              err_n = 1'b1;
            end else begin
              x_cnt  = cp_cnt;
              x_byte = cp_byte;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd.last) begin
      fin_bad = err_n || (pend_n != 2'd0) || hv_n || sv_n;
      err_n   = 1'b0;
      pend_n  = 2'd0;
      len_n   = 2'd0;
      acc_n   = '0;
      hv_n    = 1'b0;
      sv_n    = 1'b0;
    end
  end

  assign empty    = !out_valid;
  assign out_take = !out_valid || pop;
  assign rem_zero = (eb_cnt == 3'd0) && !eb_stat;
  assign rem_one  = ((eb_cnt == 3'd1) && !eb_stat) || ((eb_cnt == 3'd0) && eb_stat);
  assign move     = !rem_zero && out_take;
  assign load_ok  = rem_zero || (rem_one && move);
  assign fire     = !cmd_empty && load_ok;
  assign cmd_pop  = fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen   <= 1'b0;
      utf8_pending <= 2'd0;
      utf8_length  <= 2'd0;
      cp_acc       <= '0;
      half_valid   <= 1'b0;
      hs_valid     <= 1'b0;
      eb_cnt       <= 3'd0;
      eb_stat      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (move) begin
        out_valid         <= 1'b1;
        detected_encoding <= eb_enc;
        if (eb_cnt != 3'd0) begin
          out_byte     <= eb_byte[0];
          has_byte     <= 1'b1;
          stream_done  <= 1'b0;
          bad_encoding <= 1'b0;
        end else begin
          out_byte     <= 8'h00;
          has_byte     <= 1'b0;
          stream_done  <= 1'b1;
          bad_encoding <= eb_bad;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (fire) begin
        error_seen   <= err_n;
        utf8_pending <= pend_n;
        utf8_length  <= len_n;
        cp_acc       <= acc_n;
        half_valid   <= hv_n;
        half_byte    <= hb_n;
        hs_valid     <= sv_n;
        hs_off       <= so_n;
        eb_byte      <= x_byte;
        eb_cnt       <= x_cnt;
        eb_stat      <= cmd.last;
        eb_bad       <= fin_bad;
        eb_enc       <= cmd.enc;
      end else if (move) begin
        if (eb_cnt != 3'd0) begin
          eb_cnt     <= eb_cnt - 3'd1;
          eb_byte[0] <= eb_byte[1];
          eb_byte[1] <= eb_byte[2];
          eb_byte[2] <= eb_byte[3];
        end else begin
          eb_stat <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: hdl/bom_detect_utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// bom_detect_utf16_to_utf8_transcoder
// Byte-order-mark detecting transcoder: UTF-16 LE/BE to UTF-8, UTF-8 checked
// and passed through, one status item closing each file.
// ----------------------------------------------------------------------------
//  channel  | handshake        | fields
//  ---------+------------------+------------------------------------------------
//  input    | push / full      | in_byte, final_byte
//  result   | empty / pop      | out_byte, has_byte, stream_done,
//           |                  | detected_encoding, bad_encoding
//
//  One input item is taken per cycle unless full; the command queue decouples
//  intake from output. Results leave at one per cycle from the output register
//  while pop is held; the byte closing a surrogate pair yields four bytes, plus
//  a status item when it ends the file. Leading bytes that only look like a mark
//  are flushed together (up to three commands), holding intake meanwhile.
//  Reset is synchronous; no clearing pass. Either side may stall without loss.
// ----------------------------------------------------------------------------
`include "bom_detect_utf16_to_utf8_transcoder_macros.svh"

module bom_detect_utf16_to_utf8_transcoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       stream_done,
  output logic [1:0] detected_encoding,
  output logic       bad_encoding
);
  import bdt_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic cmd_valid, cmd_full, cmd_empty, cmd_pop;

  bdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_byte    (in_byte),
    .final_byte (final_byte),
    .full       (full),
    .cmd        (front_cmd),
    .cmd_valid  (cmd_valid),
    .cmd_full   (cmd_full)
  );

  bdt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .wdata (front_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  bdt_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd               (back_cmd),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .empty             (empty),
    .pop               (pop),
    .out_byte          (out_byte),
    .has_byte          (has_byte),
    .stream_done       (stream_done),
    .detected_encoding (detected_encoding),
    .bad_encoding      (bad_encoding)
  );

  `BDT_ASSERT_IMP(a_byte_clean, clk, rst, !empty && has_byte, !bad_encoding && !stream_done, "byte item carries status flags")
  `BDT_ASSERT_IMP(a_status_form, clk, rst, !empty && !has_byte, stream_done && out_byte == 8'h00, "malformed status item")
  `BDT_ASSERT_IMP(a_stall_has_work, clk, rst, full, cmd_valid, "intake stalled with no pending command")

endmodule
